@@ rtl/ntdc_pkg.sv @@
package ntdc_pkg;

    localparam int MAX_DIGITS_DEF = 16;

    // Highest decimal position of a 32-bit magnitude (10^9).
    localparam logic [4:0] DEC_TOP_POS = 5'd9;
    localparam logic [5:0] DEC_LIMIT   = 6'd10;
    localparam logic [5:0] HEX_LIMIT   = 6'd8;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        KIND_UDEC,
        KIND_SDEC,
        KIND_HEX,
        KIND_BIN
    } t_kind;

    typedef enum logic [1:0] {
        UOP_WAIT_IN,
        UOP_SIGN,
        UOP_TRY,
        UOP_EMIT
    } t_uop;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_HEXBIN,
        COND_MORE
    } t_cond;

    typedef logic [2:0] t_upc;

    localparam t_upc UPC_WAIT     = 3'd0;
    localparam t_upc UPC_SIGN     = 3'd1;
    localparam t_upc UPC_TRY3     = 3'd2;
    localparam t_upc UPC_TRY2     = 3'd3;
    localparam t_upc UPC_TRY1     = 3'd4;
    localparam t_upc UPC_TRY0     = 3'd5;
    localparam t_upc UPC_EMIT_DEC = 3'd6;
    localparam t_upc UPC_EMIT_HB  = 3'd7;

    // One control word: operation, trial bit for the decimal steps,
    // branch condition, and the targets taken when it holds or not.
    typedef struct packed {
        t_uop       op;
        logic [1:0] bit_k;
        t_cond      cond;
        t_upc       jt;
        t_upc       jf;
    } t_uword;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        case (pc)
            UPC_WAIT:     w = '{UOP_WAIT_IN, 2'd0, COND_ALWAYS, UPC_SIGN,    UPC_SIGN};
            UPC_SIGN:     w = '{UOP_SIGN,    2'd0, COND_HEXBIN, UPC_EMIT_HB, UPC_TRY3};
            UPC_TRY3:     w = '{UOP_TRY,     2'd3, COND_ALWAYS, UPC_TRY2,    UPC_TRY2};
            UPC_TRY2:     w = '{UOP_TRY,     2'd2, COND_ALWAYS, UPC_TRY1,    UPC_TRY1};
            UPC_TRY1:     w = '{UOP_TRY,     2'd1, COND_ALWAYS, UPC_TRY0,    UPC_TRY0};
            UPC_TRY0:     w = '{UOP_TRY,     2'd0, COND_ALWAYS, UPC_EMIT_DEC, UPC_EMIT_DEC};
            UPC_EMIT_DEC: w = '{UOP_EMIT,    2'd0, COND_MORE,   UPC_TRY3,    UPC_WAIT};
            UPC_EMIT_HB:  w = '{UOP_EMIT,    2'd0, COND_MORE,   UPC_EMIT_HB, UPC_WAIT};
            default:      w = '{UOP_WAIT_IN, 2'd0, COND_ALWAYS, UPC_WAIT,    UPC_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [31:0] dec_weight(input logic [3:0] pos);
        logic [31:0] w;
        case (pos)
            4'd0:    w = 32'd1;
            4'd1:    w = 32'd10;
            4'd2:    w = 32'd100;
            4'd3:    w = 32'd1000;
            4'd4:    w = 32'd10000;
            4'd5:    w = 32'd100000;
            4'd6:    w = 32'd1000000;
            4'd7:    w = 32'd10000000;
            4'd8:    w = 32'd100000000;
            4'd9:    w = 32'd1000000000;
            default: w = 32'd1;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/ntdc_ifs.sv @@
interface ntdc_num_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] value;
    logic [4:0]  digit_count;
    logic [2:0]  screen_line;
    logic [4:0]  start_column;

    modport source (
        output valid, kind, value, digit_count, screen_line, start_column,
        input  ready
    );
    modport sink (
        input  valid, kind, value, digit_count, screen_line, start_column,
        output ready
    );
endinterface

interface ntdc_chr_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_line;
    logic [5:0] out_column;
    logic [6:0] char_code;
    logic       last_char;

    modport source (
        output valid, out_line, out_column, char_code, last_char,
        input  ready
    );
    modport sink (
        input  valid, out_line, out_column, char_code, last_char,
        output ready
    );
endinterface

@@ rtl/number_to_digit_chars_unit.sv @@
// Converts one number item into a stream of ASCII character items, most
// significant digit first, each tagged with its screen line and column.
// A small microprogram steps a shared 36-bit compare-and-subtract unit
// that settles one bit of a decimal digit per cycle, so a decimal item
// takes one load step, one sign step, then five steps for each of the
// ten decimal positions, and a hex or binary item takes a load step, a
// sign step and an emit step per digit, or one for a zero count. A
// stalled output holds the sign and emit steps. A new item is taken only
// when the previous one has been fully stepped through; the last
// character of an item may still wait in the output register meanwhile.
module number_to_digit_chars_unit #(
    parameter int MAX_DIGITS = ntdc_pkg::MAX_DIGITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ntdc_num_if.sink         i_num,
    ntdc_chr_if.source       o_chr
);

    localparam logic [5:0] BIN_LIMIT = 6'(MAX_DIGITS);

    ntdc_pkg::t_upc   r_upc, n_upc;
    ntdc_pkg::t_kind  r_kind, n_kind;
    logic             r_neg, n_neg;
    logic [31:0]      r_mag, n_mag;
    logic [4:0]       r_count, n_count;
    logic [4:0]       r_pos, n_pos;
    logic [2:0]       r_line, n_line;
    logic [5:0]       r_col, n_col;
    logic [3:0]       r_digit, n_digit;

    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_out_line, n_out_line;
    logic [5:0]       r_out_col, n_out_col;
    logic [6:0]       r_out_char, n_out_char;
    logic             r_out_last, n_out_last;

    ntdc_pkg::t_uword w;
    ntdc_pkg::t_kind  in_kind;
    logic             slot_free;
    logic             hold;
    logic             cond_true;
    logic             emit;
    logic [6:0]       emit_char;
    logic             emit_last;
    logic [5:0]       limit;
    logic [4:0]       clamped;
    logic             in_neg;
    logic [35:0]      trial;
    logic [3:0]       nib;
    logic [6:0]       digit_char;
    logic             is_hexbin;

    assign w         = ntdc_pkg::ucode(r_upc);
    assign slot_free = !r_out_valid || o_chr.ready;
    assign in_kind   = ntdc_pkg::t_kind'(i_num.kind);
    assign is_hexbin = (r_kind == ntdc_pkg::KIND_HEX) || (r_kind == ntdc_pkg::KIND_BIN);

    assign i_num.ready      = (w.op == ntdc_pkg::UOP_WAIT_IN);
    assign o_chr.valid      = r_out_valid;
    assign o_chr.out_line   = r_out_line;
    assign o_chr.out_column = r_out_col;
    assign o_chr.char_code  = r_out_char;
    assign o_chr.last_char  = r_out_last;

    always_comb begin
        case (in_kind)
            ntdc_pkg::KIND_HEX: limit = ntdc_pkg::HEX_LIMIT;
            ntdc_pkg::KIND_BIN: limit = BIN_LIMIT;
            default:            limit = ntdc_pkg::DEC_LIMIT;
        endcase
        clamped = ({1'b0, i_num.digit_count} > limit) ? limit[4:0] : i_num.digit_count;
        in_neg  = (in_kind == ntdc_pkg::KIND_SDEC) && i_num.value[31];
    end

    always_comb begin
        trial = 36'(ntdc_pkg::dec_weight(r_pos[3:0])) << w.bit_k;
        nib   = r_mag[{r_pos[2:0], 2'b00} +: 4];
        case (r_kind)
            ntdc_pkg::KIND_HEX:
                digit_char = (nib < 4'd10) ? ntdc_pkg::CH_ZERO + 7'(nib)
                                           : ntdc_pkg::CH_UPPER_A + 7'(nib) - 7'd10;
            ntdc_pkg::KIND_BIN: digit_char = ntdc_pkg::CH_ZERO + 7'(r_mag[r_pos]);
            default:            digit_char = ntdc_pkg::CH_ZERO + 7'(r_digit);
        endcase
    end

    always_comb begin
        n_upc   = r_upc;
        n_kind  = r_kind;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_count = r_count;
        n_pos   = r_pos;
        n_line  = r_line;
        n_col   = r_col;
        n_digit = r_digit;
        hold      = 1'b0;
        emit      = 1'b0;
        emit_char = ntdc_pkg::CH_ZERO;
        emit_last = 1'b0;

        case (w.op)
            ntdc_pkg::UOP_WAIT_IN: begin
                if (i_num.valid) begin
                    n_kind  = in_kind;
                    n_neg   = in_neg;
                    n_mag   = in_neg ? (32'd0 - i_num.value) : i_num.value;
                    n_count = clamped;
                    n_line  = i_num.screen_line;
                    n_col   = {1'b0, i_num.start_column};
                    n_digit = 4'd0;
                    // Decimal walks every position from the top so that the
                    // dropped high digits are still removed from the magnitude.
                    if ((in_kind == ntdc_pkg::KIND_HEX) || (in_kind == ntdc_pkg::KIND_BIN)) begin
                        n_pos = (clamped == 5'd0) ? 5'd0 : clamped - 5'd1;
                    end else begin
                        n_pos = ntdc_pkg::DEC_TOP_POS;
                    end
                end else begin
                    hold = 1'b1;
                end
            end
            ntdc_pkg::UOP_SIGN: begin
                if (r_kind == ntdc_pkg::KIND_SDEC) begin
                    if (slot_free) begin
                        emit      = 1'b1;
                        emit_char = r_neg ? ntdc_pkg::CH_MINUS : ntdc_pkg::CH_PLUS;
                        emit_last = (r_count == 5'd0);
                        n_col     = r_col + 6'd1;
                    end else begin
                        hold = 1'b1;
                    end
                end
            end
            ntdc_pkg::UOP_TRY: begin
                if ({4'd0, r_mag} >= trial) begin
                    n_mag            = r_mag - trial[31:0];
                    n_digit[w.bit_k] = 1'b1;
                end
            end
            ntdc_pkg::UOP_EMIT: begin
                if ((r_pos < r_count) && !slot_free) begin
                    hold = 1'b1;
                end else begin
                    if (r_pos < r_count) begin
                        emit      = 1'b1;
                        emit_char = digit_char;
                        emit_last = (r_pos == 5'd0);
                        n_col     = r_col + 6'd1;
                    end
                    if (r_pos != 5'd0) begin
                        n_pos = r_pos - 5'd1;
                    end
                    n_digit = 4'd0;
                end
            end
            default: begin
                hold = 1'b1;
            end
        endcase

        case (w.cond)
            ntdc_pkg::COND_HEXBIN: cond_true = is_hexbin;
            ntdc_pkg::COND_MORE:   cond_true = (r_pos != 5'd0);
            default:               cond_true = 1'b1;
        endcase

        if (!hold) begin
            n_upc = cond_true ? w.jt : w.jf;
        end

        n_out_valid = r_out_valid;
        n_out_line  = r_out_line;
        n_out_col   = r_out_col;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_line  = r_line;
            n_out_col   = r_col;
            n_out_char  = emit_char;
            n_out_last  = emit_last;
        end else if (o_chr.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= ntdc_pkg::UPC_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_count    <= n_count;
        r_pos      <= n_pos;
        r_line     <= n_line;
        r_col      <= n_col;
        r_digit    <= n_digit;
        r_out_line <= n_out_line;
        r_out_col  <= n_out_col;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

endmodule

@@ rtl/ntdc_checker.sv @@
module ntdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_out_line,
    input logic [5:0] i_out_column,
    input logic [6:0] i_out_char,
    input logic       i_out_last
);

    logic       r_seen;
    logic       r_prev_last;
    logic [2:0] r_prev_line;
    logic [5:0] r_prev_col;
    logic       out_accept;

    assign out_accept = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (out_accept) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_accept) begin
            r_prev_last <= i_out_last;
            r_prev_line <= i_out_line;
            r_prev_col  <= i_out_column;
        end
    end

    // A waiting character item keeps its contents until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_column) && $stable(i_out_last))
        else $error("character item changed while stalled");

    // A take moves the microprogram on to its sign step, so input is closed right after a take.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken on consecutive cycles");

    // Within one number the characters sit in consecutive columns of one line.
    a_columns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && r_seen && !r_prev_last |->
            (i_out_column == r_prev_col + 6'd1) && (i_out_line == r_prev_line))
        else $error("character column or line out of sequence");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

endmodule

bind number_to_digit_chars_unit ntdc_checker u_ntdc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_num.valid),
    .i_in_ready   (i_num.ready),
    .i_out_valid  (o_chr.valid),
    .i_out_ready  (o_chr.ready),
    .i_out_line   (o_chr.out_line),
    .i_out_column (o_chr.out_column),
    .i_out_char   (o_chr.char_code),
    .i_out_last   (o_chr.last_char)
);
